// ----- rtl/core/hsvr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_pkg - shared types and constants of the HSV to RGB8 converter
// Transaction structs, sector codes, stage enables and the fixed-point
// constants of the colour scaling.
// ----------------------------------------------------------------------------
package hsvr_pkg;

	// Operand limits and the expected payload length
	localparam int unsigned HUE_MAX     = 359;
	localparam int unsigned PCT_MAX     = 100;
	localparam int unsigned CMD_BYTES   = 4;
	localparam int unsigned SECTOR_SPAN = 60;

	// Every channel is V * A * 255 / 600000 with A in 0..6000, and
	// 255 / 600000 reduces to 17 / 40000 = 17 / (64 * 625).
	localparam int unsigned FULL_SPAN   = 6000;
	localparam int unsigned SCALE_MUL   = 17;
	localparam int unsigned PRE_SHIFT   = 6;
	localparam int unsigned DIVISOR     = 625;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / DIVISOR;

	// Internal widths
	localparam int unsigned PCT_W  = 7;   // 0..100
	localparam int unsigned REM_W  = 6;   // 0..59
	localparam int unsigned SPAN_W = 13;  // 0..6000
	localparam int unsigned V17_W  = 11;  // 0..1700
	localparam int unsigned PROD_W = 24;  // 0..10.2e6
	localparam int unsigned QUOT_W = PROD_W - PRE_SHIFT;
	localparam int unsigned EST_W  = 32;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness_value;
		logic [7:0]  payload_length;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       status;
	} rgb_t;

	// Load enables, one for each pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage
`default_nettype wire

// ----- rtl/core/hsvr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_front - operand check, hue sector split and channel spans
// Stage 1 validates the transaction and splits the hue; stage 2 forms the
// per-channel spans A (0..6000) and the value multiple V*17.
// ----------------------------------------------------------------------------
module hsvr_front (
	input  wire logic                           clk,
	input  wire hsvr_pkg::stage_en_t            en,
	input  wire hsvr_pkg::hsv_t                 hsv,
	output logic                                err_s2,
	output hsvr_pkg::sector_t                   sector_s2,
	output logic [hsvr_pkg::V17_W-1:0]          v17_s2,
	output logic [hsvr_pkg::SPAN_W-1:0]         ap_s2,
	output logic [hsvr_pkg::SPAN_W-1:0]         aq_s2,
	output logic [hsvr_pkg::SPAN_W-1:0]         at_s2
);

	logic                          err;
	logic [8:0]                    hue9;
	hsvr_pkg::sector_t             sector;
	logic [8:0]                    base;
	logic [8:0]                    rem9;

	logic                          err_s1;
	hsvr_pkg::sector_t             sector_s1;
	logic [hsvr_pkg::REM_W-1:0]    rem_s1;
	logic [hsvr_pkg::PCT_W-1:0]    sat_s1;
	logic [hsvr_pkg::PCT_W-1:0]    val_s1;

	logic [hsvr_pkg::SPAN_W-1:0]   s_rem;
	logic [hsvr_pkg::SPAN_W-1:0]   s_span;
	logic [hsvr_pkg::SPAN_W-1:0]   ap;

	assign err = (hsv.payload_length != 8'(hsvr_pkg::CMD_BYTES))
		|| (hsv.hue > 16'(hsvr_pkg::HUE_MAX))
		|| (hsv.saturation > 8'(hsvr_pkg::PCT_MAX))
		|| (hsv.brightness_value > 8'(hsvr_pkg::PCT_MAX));

	assign hue9 = hsv.hue[8:0];

	// Sector by compare ladder; out-of-range hues are flagged and ignored
	always_comb begin
		priority if (hue9 >= 9'(5 * hsvr_pkg::SECTOR_SPAN)) begin
			sector = hsvr_pkg::SEC_MAG_RED;
			base   = 9'(5 * hsvr_pkg::SECTOR_SPAN);
		end else if (hue9 >= 9'(4 * hsvr_pkg::SECTOR_SPAN)) begin
			sector = hsvr_pkg::SEC_BLU_MAG;
			base   = 9'(4 * hsvr_pkg::SECTOR_SPAN);
		end else if (hue9 >= 9'(3 * hsvr_pkg::SECTOR_SPAN)) begin
			sector = hsvr_pkg::SEC_CYN_BLU;
			base   = 9'(3 * hsvr_pkg::SECTOR_SPAN);
		end else if (hue9 >= 9'(2 * hsvr_pkg::SECTOR_SPAN)) begin
			sector = hsvr_pkg::SEC_GRN_CYN;
			base   = 9'(2 * hsvr_pkg::SECTOR_SPAN);
		end else if (hue9 >= 9'(hsvr_pkg::SECTOR_SPAN)) begin
			sector = hsvr_pkg::SEC_YEL_GRN;
			base   = 9'(hsvr_pkg::SECTOR_SPAN);
		end else begin
			sector = hsvr_pkg::SEC_RED_YEL;
			base   = 9'd0;
		end
	end

	assign rem9 = hue9 - base;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			err_s1    <= err;
			sector_s1 <= sector;
			rem_s1    <= rem9[hsvr_pkg::REM_W-1:0];
			sat_s1    <= hsv.saturation[hsvr_pkg::PCT_W-1:0];
			val_s1    <= hsv.brightness_value[hsvr_pkg::PCT_W-1:0];
		end
	end

	// A_p = 6000 - 60S, A_q = 6000 - S*rem, A_t = A_p + S*rem
	assign s_rem  = hsvr_pkg::SPAN_W'(sat_s1) * hsvr_pkg::SPAN_W'(rem_s1);
	assign s_span = hsvr_pkg::SPAN_W'(sat_s1) * hsvr_pkg::SPAN_W'(hsvr_pkg::SECTOR_SPAN);
	assign ap     = hsvr_pkg::SPAN_W'(hsvr_pkg::FULL_SPAN) - s_span;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			err_s2    <= err_s1;
			sector_s2 <= sector_s1;
			v17_s2    <= hsvr_pkg::V17_W'(val_s1) * hsvr_pkg::V17_W'(hsvr_pkg::SCALE_MUL);
			ap_s2     <= ap;
			aq_s2     <= hsvr_pkg::SPAN_W'(hsvr_pkg::FULL_SPAN) - s_rem;
			at_s2     <= ap + s_rem;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/hsvr_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsvr_scale - one colour channel, floor(V*17*A / 40000)
// Stage 3 forms the product, stage 4 a reciprocal estimate of the quotient
// by 625; the one-step correction follows the stage 4 registers.
// ----------------------------------------------------------------------------
module hsvr_scale (
	input  wire logic                           clk,
	input  wire hsvr_pkg::stage_en_t            en,
	input  wire logic [hsvr_pkg::V17_W-1:0]     v17,
	input  wire logic [hsvr_pkg::SPAN_W-1:0]    span,
	output logic [7:0]                          colour
);

	logic [hsvr_pkg::PROD_W-1:0]  prod_s3;
	logic [hsvr_pkg::QUOT_W-1:0]  quot;
	logic [hsvr_pkg::EST_W-1:0]   recip_prod;
	logic [hsvr_pkg::QUOT_W-1:0]  quot_s4;
	logic [7:0]                   est_s4;
	logic [hsvr_pkg::QUOT_W-1:0]  back;
	logic [hsvr_pkg::QUOT_W-1:0]  resid;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= hsvr_pkg::PROD_W'(v17) * hsvr_pkg::PROD_W'(span);
		end
	end

	// Drop the factor 64 by shifting, then estimate the quotient by 625
	assign quot       = prod_s3[hsvr_pkg::PROD_W-1:hsvr_pkg::PRE_SHIFT];
	assign recip_prod = hsvr_pkg::EST_W'(quot) * hsvr_pkg::EST_W'(hsvr_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			quot_s4 <= quot;
			est_s4  <= recip_prod[hsvr_pkg::RECIP_SHIFT+7:hsvr_pkg::RECIP_SHIFT];
		end
	end

	// The estimate is exact or one short
	assign back   = hsvr_pkg::QUOT_W'(est_s4) * hsvr_pkg::QUOT_W'(hsvr_pkg::DIVISOR);
	assign resid  = quot_s4 - back;
	assign colour = (resid >= hsvr_pkg::QUOT_W'(hsvr_pkg::DIVISOR)) ? est_s4 + 8'd1 : est_s4;

endmodule
`default_nettype wire

// ----- rtl/core/hsv_percent_to_rgb8_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_percent_to_rgb8_unit - HSV (degrees, percent) to 8-bit RGB converter
// Five-stage pipeline: operand check and hue split, channel spans, products,
// reciprocal division, sector selection into the output register.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload              | role
//   --------+------------------------+----------------------+-----------------
//   hsv     | hsv_valid / hsv_ready  | hsv  (hsvr_pkg::hsv_t) | colour in
//   rgb     | rgb_valid / rgb_ready  | rgb  (hsvr_pkg::rgb_t) | colour + status
//
// The accepting edge loads stage 1; stages 2, 3 and 4 and then the output
// register carry the transaction on to rgb_valid. One transaction is taken
// every cycle while the output side keeps up.
// Each stage loads whenever it is empty or its successor loads, so bubbles
// close up and a stalled output holds every occupied stage in place.
// arst_n clears only the stage valid bits; payload registers are not reset.
// Error transactions (bad length or operand) leave with status set and
// all colours zero.
//
// ----------------------------------------------------------------------------
module hsv_percent_to_rgb8_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            hsv_valid,
	output logic                 hsv_ready,
	input  wire hsvr_pkg::hsv_t  hsv,
	output logic                 rgb_valid,
	input  wire logic            rgb_ready,
	output hsvr_pkg::rgb_t       rgb
);

	hsvr_pkg::stage_en_t              en;
	logic                             valid_s1;
	logic                             valid_s2;
	logic                             valid_s3;
	logic                             valid_s4;

	logic                             err_s2;
	hsvr_pkg::sector_t                sector_s2;
	logic [hsvr_pkg::V17_W-1:0]       v17_s2;
	logic [hsvr_pkg::SPAN_W-1:0]      ap_s2;
	logic [hsvr_pkg::SPAN_W-1:0]      aq_s2;
	logic [hsvr_pkg::SPAN_W-1:0]      at_s2;

	logic                             err_s3;
	hsvr_pkg::sector_t                sector_s3;
	logic                             err_s4;
	hsvr_pkg::sector_t                sector_s4;

	logic [7:0]                       c_val;
	logic [7:0]                       c_p;
	logic [7:0]                       c_q;
	logic [7:0]                       c_t;
	hsvr_pkg::rgb_t                   rgb_next;

	// Stage enables: advance into a stage when it is empty or it drains
	assign en.s5     = !rgb_valid || rgb_ready;
	assign en.s4     = !valid_s4  || en.s5;
	assign en.s3     = !valid_s3  || en.s4;
	assign en.s2     = !valid_s2  || en.s3;
	assign en.s1     = !valid_s1  || en.s2;
	assign hsv_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			rgb_valid <= 1'b0;
		end else begin
			if (en.s1) valid_s1  <= hsv_valid;
			if (en.s2) valid_s2  <= valid_s1;
			if (en.s3) valid_s3  <= valid_s2;
			if (en.s4) valid_s4  <= valid_s3;
			if (en.s5) rgb_valid <= valid_s4;
		end
	end

	// Stages 1 and 2: operand check, sector split, spans
	hsvr_front u_front (
		.clk       (clk),
		.en        (en),
		.hsv       (hsv),
		.err_s2    (err_s2),
		.sector_s2 (sector_s2),
		.v17_s2    (v17_s2),
		.ap_s2     (ap_s2),
		.aq_s2     (aq_s2),
		.at_s2     (at_s2)
	);

	// Stages 3 and 4: one scaler for each of val, p, q and t
	hsvr_scale u_scale_val (
		.clk    (clk),
		.en     (en),
		.v17    (v17_s2),
		.span   (hsvr_pkg::SPAN_W'(hsvr_pkg::FULL_SPAN)),
		.colour (c_val)
	);

	hsvr_scale u_scale_p (
		.clk    (clk),
		.en     (en),
		.v17    (v17_s2),
		.span   (ap_s2),
		.colour (c_p)
	);

	hsvr_scale u_scale_q (
		.clk    (clk),
		.en     (en),
		.v17    (v17_s2),
		.span   (aq_s2),
		.colour (c_q)
	);

	hsvr_scale u_scale_t (
		.clk    (clk),
		.en     (en),
		.v17    (v17_s2),
		.span   (at_s2),
		.colour (c_t)
	);

	// Carry the sector and error flag alongside the scalers
	always_ff @(posedge clk) begin
		if (en.s3) begin
			err_s3    <= err_s2;
			sector_s3 <= sector_s2;
		end
		if (en.s4) begin
			err_s4    <= err_s3;
			sector_s4 <= sector_s3;
		end
	end

	// Stage 5: route channels by sector; zero the colours on error.
	// Zero saturation needs no special path: every span is then 6000.
	always_comb begin
		unique case (sector_s4)
			hsvr_pkg::SEC_RED_YEL: begin
				rgb_next.red = c_val; rgb_next.green = c_t;   rgb_next.blue = c_p;
			end
			hsvr_pkg::SEC_YEL_GRN: begin
				rgb_next.red = c_q;   rgb_next.green = c_val; rgb_next.blue = c_p;
			end
			hsvr_pkg::SEC_GRN_CYN: begin
				rgb_next.red = c_p;   rgb_next.green = c_val; rgb_next.blue = c_t;
			end
			hsvr_pkg::SEC_CYN_BLU: begin
				rgb_next.red = c_p;   rgb_next.green = c_q;   rgb_next.blue = c_val;
			end
			hsvr_pkg::SEC_BLU_MAG: begin
				rgb_next.red = c_t;   rgb_next.green = c_p;   rgb_next.blue = c_val;
			end
			default: begin
				rgb_next.red = c_val; rgb_next.green = c_p;   rgb_next.blue = c_q;
			end
		endcase
		rgb_next.status = err_s4;
		if (err_s4) begin
			rgb_next.red   = 8'd0;
			rgb_next.green = 8'd0;
			rgb_next.blue  = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			rgb <= rgb_next;
		end
	end

`ifndef NO_ASSERTIONS
	// An error transaction never carries colour
	assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb.status |-> rgb.red == 8'd0 && rgb.green == 8'd0
			&& rgb.blue == 8'd0)
		else $error("error transaction carries non-zero colour");

	// Input back-pressure only when the whole pipe is full and the output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_ready |-> rgb_valid && !rgb_ready && valid_s1 && valid_s2
			&& valid_s3 && valid_s4)
		else $error("input stalled while the pipeline has room");

	// A stalled stage 4 keeps its transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !en.s4 |=> valid_s4)
		else $error("stalled stage 4 lost its transaction");
`endif

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - HSV (degrees, percent) to RGB8 converter
// Sends a directed set of edge and error colours and then about twelve
// hundred random ones through the valid/ready input. Every result is checked
// field by field against a behavioural six-sector conversion. Both sides of
// the converter idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import hsvr_pkg::*;

	// Scaling constants of the integer conversion
	localparam longint unsigned LEVEL_MAX  = 255;
	localparam longint unsigned PCT_DEN    = 100;
	localparam longint unsigned PCT_SQ_DEN = 10000;
	localparam longint unsigned ARC_FULL   = 36000;
	localparam longint unsigned ARC_DEN    = 3600000;
	localparam longint unsigned ARC_SPAN   = 360;
	localparam longint unsigned FRAC_STEP  = 6;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_BAD = 1'b1;

	localparam int RANDOM_ITEMS = 1230;
	localparam int PRINT_CAP    = 30;

	// Receiver stall patterns, each held for a window of cycles
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_RHYTHM
	} rx_mode_t;
	localparam int RX_WINDOW = 50;

	logic clk;
	logic arst_n;
	logic hsv_valid;
	logic hsv_ready;
	hsv_t hsv;
	logic rgb_valid;
	logic rgb_ready;
	rgb_t rgb;

	hsv_t     hsv_backlog[$];
	rgb_t     colours_due[$];
	logic     hsv_taken;
	int       burst_left;
	int       gap_left;
	rx_mode_t rx_mode;
	int       rx_tick;

	int mismatches;
	int colours_out;
	int rejected_in;
	int grey_in;
	int sector_hits[6];

	hsv_percent_to_rgb8_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	// Expected colour for one input transaction
	function automatic rgb_t convert_hsv(input hsv_t px);
		longint unsigned h, s, v, sec, frac, level, p, q, t;
		rgb_t c;
		c = '0;
		h = px.hue;
		s = px.saturation;
		v = px.brightness_value;
		if (px.payload_length != CMD_BYTES || h > HUE_MAX || s > PCT_MAX || v > PCT_MAX) begin
			c.status = ST_BAD;
			return c;
		end
		c.status = ST_OK;
		level = v * LEVEL_MAX / PCT_DEN;
		if (s == 0) begin
			c.red   = level[7:0];
			c.green = level[7:0];
			c.blue  = level[7:0];
			return c;
		end
		sec  = h / SECTOR_SPAN;
		frac = (h - sec * SECTOR_SPAN) * FRAC_STEP;
		p = v * (PCT_DEN - s) * LEVEL_MAX / PCT_SQ_DEN;
		q = v * (ARC_FULL - s * frac) * LEVEL_MAX / ARC_DEN;
		t = v * (ARC_FULL - s * (ARC_SPAN - frac)) * LEVEL_MAX / ARC_DEN;
		case (sector_t'(sec[2:0]))
			SEC_RED_YEL: begin c.red = level[7:0]; c.green = t[7:0];     c.blue = p[7:0]; end
			SEC_YEL_GRN: begin c.red = q[7:0];     c.green = level[7:0]; c.blue = p[7:0]; end
			SEC_GRN_CYN: begin c.red = p[7:0];     c.green = level[7:0]; c.blue = t[7:0]; end
			SEC_CYN_BLU: begin c.red = p[7:0];     c.green = q[7:0];     c.blue = level[7:0]; end
			SEC_BLU_MAG: begin c.red = t[7:0];     c.green = p[7:0];     c.blue = level[7:0]; end
			default:     begin c.red = level[7:0]; c.green = p[7:0];     c.blue = q[7:0]; end
		endcase
		return c;
	endfunction

	task automatic queue_pixel(input int unsigned h, input int unsigned s,
			input int unsigned v, input int unsigned len);
		hsv_t px;
		px.hue              = h[15:0];
		px.saturation       = s[7:0];
		px.brightness_value = v[7:0];
		px.payload_length   = len[7:0];
		hsv_backlog.push_back(px);
	endtask

	// Mostly well-formed colours, the rest out of range, bad length or noise
	task automatic queue_random_pixel();
		int unsigned roll, h, s, v, len;
		roll = $urandom_range(0, 99);
		h    = $urandom_range(0, HUE_MAX);
		s    = $urandom_range(1, PCT_MAX);
		v    = $urandom_range(0, PCT_MAX);
		len  = CMD_BYTES;
		// bias some hues onto sector borders
		if ($urandom_range(0, 7) == 0)
			h = SECTOR_SPAN * $urandom_range(0, 5) + (($urandom_range(0, 1) == 0) ? 0 : 59);
		if (roll < 8)
			s = 0;
		else if (roll < 12)
			h = $urandom_range(HUE_MAX + 1, 16'hFFFF);
		else if (roll < 15)
			s = $urandom_range(PCT_MAX + 1, 8'hFF);
		else if (roll < 18)
			v = $urandom_range(PCT_MAX + 1, 8'hFF);
		else if (roll < 23) begin
			len = $urandom_range(0, 8'hFF);
			if (len == CMD_BYTES)
				len = len ^ (1 << $urandom_range(0, 7));
		end else if (roll < 28) begin
			h   = $urandom_range(0, 16'hFFFF);
			s   = $urandom_range(0, 8'hFF);
			v   = $urandom_range(0, 8'hFF);
			len = $urandom_range(0, 8'hFF);
		end
		queue_pixel(h, s, v, len);
	endtask

	// Print one line per mismatch (up to a cap) and count every one
	task automatic log_mismatch(input string what, input int unsigned got, input int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] result %0d: %s got %0d expected %0d", $time, colours_out, what, got, want);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset, then release it on a falling edge
	initial begin
		arst_n    = 1'b0;
		hsv_valid = 1'b0;
		hsv       = '0;
		rgb_ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: take transactions from the backlog in bursts with gaps between
	always @(negedge clk) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
		end else if (hsv_valid && !hsv_taken) begin
			// hold the current transaction until it is taken
		end else if (gap_left != 0) begin
			hsv_valid <= 1'b0;
			gap_left  <= gap_left - 1;
		end else if (hsv_backlog.size() != 0) begin
			hsv       <= hsv_backlog.pop_front();
			hsv_valid <= 1'b1;
			if (burst_left <= 1) begin
				// a long unbroken burst now and then, otherwise a short one
				burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
				gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			hsv_valid <= 1'b0;
		end
	end

	// Receiver: stall on a pattern that changes every window
	always @(negedge clk) begin
		if (!arst_n) begin
			rgb_ready <= 1'b0;
		end else begin
			if (rx_tick == RX_WINDOW - 1) begin
				rx_tick <= 0;
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			end else begin
				rx_tick <= rx_tick + 1;
			end
			case (rx_mode)
				RX_OPEN:   rgb_ready <= 1'b1;
				RX_COIN:   rgb_ready <= $urandom_range(0, 1);
				RX_SPARSE: rgb_ready <= ($urandom_range(0, 3) == 0);
				default:   rgb_ready <= (rx_tick % 7) < 3;
			endcase
		end
	end

	// Monitor: check results on the output side, predict on the input side
	always @(posedge clk) begin
		rgb_t want;
		rgb_t due;
		if (!arst_n) begin
			hsv_taken <= 1'b0;
		end else begin
			hsv_taken <= hsv_valid && hsv_ready;
			if (rgb_valid && rgb_ready) begin
				if (colours_due.size() == 0) begin
					mismatches++;
					if (mismatches <= PRINT_CAP)
						$display("[%0t] result with no transaction outstanding", $time);
				end else begin
					due = colours_due.pop_front();
					if (rgb.red !== due.red)
						log_mismatch("red", rgb.red, due.red);
					if (rgb.green !== due.green)
						log_mismatch("green", rgb.green, due.green);
					if (rgb.blue !== due.blue)
						log_mismatch("blue", rgb.blue, due.blue);
					if (rgb.status !== due.status)
						log_mismatch("status", rgb.status, due.status);
				end
				colours_out++;
			end
			if (hsv_valid && hsv_ready) begin
				want = convert_hsv(hsv);
				colours_due.push_back(want);
				if (want.status == ST_BAD)
					rejected_in++;
				else if (hsv.saturation == 0)
					grey_in++;
				else
					sector_hits[hsv.hue / SECTOR_SPAN]++;
			end
		end
	end

	// Fill the backlog, then wait for the pipeline to drain
	initial begin
		mismatches  = 0;
		colours_out = 0;
		rejected_in = 0;
		grey_in     = 0;
		burst_left  = 8;
		gap_left    = 0;
		rx_mode     = RX_OPEN;
		rx_tick     = 0;
		foreach (sector_hits[i])
			sector_hits[i] = 0;

		// wrong payload lengths with good operands
		queue_pixel(0, 50, 50, 0);
		queue_pixel(120, 50, 50, 3);
		queue_pixel(240, 50, 50, 5);
		queue_pixel(300, 50, 50, 255);
		// operands just past and far past their limits
		queue_pixel(360, 50, 50, CMD_BYTES);
		queue_pixel(65535, 255, 255, CMD_BYTES);
		queue_pixel(10, 101, 50, CMD_BYTES);
		queue_pixel(10, 255, 50, CMD_BYTES);
		queue_pixel(10, 50, 101, CMD_BYTES);
		queue_pixel(10, 50, 255, CMD_BYTES);
		// zero saturation gives grey
		queue_pixel(0, 0, 0, CMD_BYTES);
		queue_pixel(200, 0, 100, CMD_BYTES);
		queue_pixel(359, 0, 33, CMD_BYTES);
		// every sector at full saturation and value
		for (int sec = 0; sec < 6; sec++)
			queue_pixel(sec * SECTOR_SPAN, PCT_MAX, PCT_MAX, CMD_BYTES);
		// sector ends, lowest saturation, black with colour
		queue_pixel(59, PCT_MAX, PCT_MAX, CMD_BYTES);
		queue_pixel(HUE_MAX, PCT_MAX, PCT_MAX, CMD_BYTES);
		queue_pixel(179, 1, 100, CMD_BYTES);
		queue_pixel(90, 100, 0, CMD_BYTES);
		queue_pixel(270, 37, 71, CMD_BYTES);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			queue_random_pixel();

		@(posedge arst_n);
		while (hsv_backlog.size() != 0 || hsv_valid)
			@(posedge clk);
		while (colours_due.size() != 0)
			@(posedge clk);
		// let a stray result surface if one is coming
		repeat (20) @(posedge clk);

		$display("Checked %0d results: %0d rejected, %0d grey.", colours_out, rejected_in, grey_in);
		$display("Sector hits: %0d %0d %0d %0d %0d %0d, mismatches %0d.", sector_hits[0],
			sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5],
			mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Give up long after the slowest correct run would have ended
	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding.", colours_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/hsvr_pkg.sv
rtl/core/hsvr_front.sv
rtl/core/hsvr_scale.sv
rtl/core/hsv_percent_to_rgb8_unit.sv
sim/testbench.sv
